### hw/rtl/fvcc_pkg.sv
// Shared types, constants and tables of the flow vector color coder.
package fvcc_pkg;

   localparam int FLOW_WIDTH_DEF = 16;
   localparam int CORDIC_STEPS   = 24;
   localparam int DIV_STEPS      = 17;
   localparam int CNT_W          = 5;
   localparam int PHASE_W        = 32;
   localparam int NORM_W         = 17;
   localparam int WHEEL_LAST     = 54;
   localparam int WHEEL_IDX_W    = 6;
   localparam int CHAN_W         = 24;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_SCAN  = 2'd1,
      MODE_COLOR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2,
      CH_NONE  = 2'd3
   } chan_type;

   typedef struct packed {
      logic                 load;
      logic                 clear_max;
      logic                 square;
      logic                 sqrt_init;
      logic                 sqrt_step;
      logic                 update_max;
      logic                 cordic_step;
      logic                 div_step;
      logic                 hue;
      logic                 chan_mix;
      logic                 chan_mult;
      logic                 chan_write;
      logic                 out_load;
      logic [CNT_W-1:0]     idx;
   } cmd_type;

   typedef struct packed {
      logic max_zero;
      logic outside;
      logic out_free;
   } status_type;

   // Color wheel entries as {red, green, blue}.
   localparam logic [CHAN_W-1:0] WHEEL_TABLE [0:WHEEL_LAST] = '{
      24'hFF0000, 24'hFF1100, 24'hFF2200, 24'hFF3300, 24'hFF4400,
      24'hFF5500, 24'hFF6600, 24'hFF7700, 24'hFF8800, 24'hFF9900,
      24'hFFAA00, 24'hFFBB00, 24'hFFCC00, 24'hFFDD00, 24'hFFEE00,
      24'hFFFF00, 24'hD5FF00, 24'hAAFF00, 24'h80FF00, 24'h55FF00,
      24'h2BFF00,
      24'h00FF00, 24'h00FF3F, 24'h00FF7F, 24'h00FFBF,
      24'h00FFFF, 24'h00E8FF, 24'h00D1FF, 24'h00BAFF, 24'h00A3FF,
      24'h008CFF, 24'h0074FF, 24'h005DFF, 24'h0046FF, 24'h002FFF,
      24'h0018FF,
      24'h0000FF, 24'h1300FF, 24'h2700FF, 24'h3A00FF, 24'h4E00FF,
      24'h6200FF, 24'h7500FF, 24'h8900FF, 24'h9C00FF, 24'hB000FF,
      24'hC400FF, 24'hD700FF, 24'hEB00FF,
      24'hFF00FF, 24'hFF00D5, 24'hFF00AA, 24'hFF0080, 24'hFF0055,
      24'hFF002B
   };

   function automatic logic [PHASE_W-1:0] atan_turns(input logic [CNT_W-1:0] i);
      logic [PHASE_W-1:0] a;
      case (i)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051E;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2F;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2FA;
         5'd15:   a = 32'h0000517D;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A30;
         5'd19:   a = 32'h00000518;
         5'd20:   a = 32'h0000028C;
         5'd21:   a = 32'h00000146;
         5'd22:   a = 32'h000000A3;
         5'd23:   a = 32'h00000051;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

### hw/rtl/fvcc_ctrl.sv
// Sequencer of the flow vector color coder: walks each beat through its steps.
module fvcc_ctrl #(
   parameter int FLOW_WIDTH = fvcc_pkg::FLOW_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_mode,
   input  logic                 req_flow_unknown,
   input  fvcc_pkg::status_type status,
   output fvcc_pkg::cmd_type    cmd
);
   import fvcc_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_SQUARE = 11'b00000000010,
      ST_SQINIT = 11'b00000000100,
      ST_SQRT   = 11'b00000001000,
      ST_UPDATE = 11'b00000010000,
      ST_CORDIC = 11'b00000100000,
      ST_DIV    = 11'b00001000000,
      ST_HUE    = 11'b00010000000,
      ST_MIX    = 11'b00100000000,
      ST_MULT   = 11'b01000000000,
      ST_WRITE  = 11'b10000000000
   } state_type;

   localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(FLOW_WIDTH - 1);
   localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
   localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_STEPS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             scan_ff, scan_in;
   logic             done_ff, done_in;
   logic             accept;
   mode_type         mode;

   assign mode      = mode_type'(req_mode);
   assign req_stall = (state_ff != ST_IDLE) || done_ff;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      scan_in  = scan_ff;
      done_in  = done_ff;
      cmd      = '0;
      cmd.idx  = cnt_ff;
      if (done_ff && status.out_free) begin
         cmd.out_load = 1'b1;
         done_in      = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               scan_in  = (mode == MODE_SCAN);
               case (mode)
                  MODE_CLEAR: cmd.clear_max = 1'b1;
                  MODE_SCAN:  state_in = ST_SQUARE;
                  MODE_COLOR: begin
                     if (req_flow_unknown) begin
                        done_in = 1'b1;
                     end else begin
                        state_in = ST_SQUARE;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_SQINIT;
         end
         ST_SQINIT: begin
            cmd.sqrt_init = 1'b1;
            cnt_in        = '0;
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               cnt_in   = '0;
               state_in = scan_ff ? ST_UPDATE : ST_CORDIC;
            end
         end
         ST_UPDATE: begin
            cmd.update_max = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == CORDIC_LAST) begin
               cnt_in   = '0;
               state_in = (status.max_zero || status.outside) ? ST_HUE : ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_HUE;
            end
         end
         ST_HUE: begin
            cmd.hue  = 1'b1;
            cnt_in   = CNT_W'(CH_RED);
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.chan_mix = 1'b1;
            state_in     = ST_MULT;
         end
         ST_MULT: begin
            cmd.chan_mult = 1'b1;
            state_in      = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.chan_write = 1'b1;
            if (cnt_ff == CNT_W'(CH_BLUE)) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_MIX;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         scan_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         scan_ff  <= scan_in;
         done_ff  <= done_in;
      end
   end

endmodule

### hw/rtl/fvcc_datapath.sv
// Datapath of the flow vector color coder: root, CORDIC, divider, blend.
module fvcc_datapath #(
   parameter int FLOW_WIDTH = fvcc_pkg::FLOW_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fvcc_pkg::cmd_type            cmd,
   output fvcc_pkg::status_type         status,
   input  logic signed [FLOW_WIDTH-1:0] req_flow_x,
   input  logic signed [FLOW_WIDTH-1:0] req_flow_y,
   input  logic                         req_flow_unknown,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_red,
   output logic [7:0]                   rsp_green,
   output logic [7:0]                   rsp_blue
);
   import fvcc_pkg::*;

   localparam int RAD_W  = FLOW_WIDTH + 1;
   localparam int SQ_W   = 2 * FLOW_WIDTH;
   localparam int REM_W  = FLOW_WIDTH + 3;
   localparam int CW     = FLOW_WIDTH + 18;
   localparam int FK_W   = PHASE_W + WHEEL_IDX_W;
   localparam int PROD_W = NORM_W + CHAN_W;
   localparam logic [CHAN_W-1:0] FULL = CHAN_W'(255 * 65536);

   logic signed [FLOW_WIDTH-1:0] fx_ff, fy_ff;
   logic                         unk_ff;
   logic [SQ_W-1:0]              sqx_ff, sqy_ff, v_ff;
   logic [REM_W-1:0]             rem_ff;
   logic [FLOW_WIDTH-1:0]        root_ff;
   logic [RAD_W-1:0]             max_ff, rad;
   logic signed [CW-1:0]         x_ff, y_ff;
   logic [PHASE_W-1:0]           z_ff;
   logic                         axis_ff;
   logic [RAD_W:0]               drem_ff;
   logic [NORM_W-1:0]            q_ff;
   logic [WHEEL_IDX_W-1:0]       k0_ff;
   logic [15:0]                  f_ff;
   logic [CHAN_W-1:0]            c_ff;
   logic [PROD_W-1:0]            prod_ff;
   logic [7:0]                   red_ff, green_ff, blue_ff;
   logic                         rsp_valid_ff;
   logic [7:0]                   rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   logic [REM_W-1:0]             rem_t, trial;
   logic signed [CW-1:0]         x0, y0, xs, ys;
   logic [RAD_W:0]               dtrial;
   logic [FK_W-1:0]              fk;
   logic [CHAN_W-1:0]            e0, e1;
   logic [7:0]                   c0, c1;
   logic [16:0]                  wf, wi;
   logic [CHAN_W:0]              mix;
   logic [PROD_W:0]              ceil_sum;
   logic [CHAN_W+1:0]            dark;
   logic [7:0]                   chan_val;
   logic                         in_range;

   assign rad             = RAD_W'(root_ff);
   assign status.max_zero = (max_ff == '0);
   assign status.outside  = (rad > max_ff);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign in_range        = status.max_zero || !status.outside;

   // digit-by-digit square root, one result bit per step
   assign rem_t = {rem_ff[REM_W-3:0], v_ff[SQ_W-1 -: 2]};
   assign trial = REM_W'({root_ff, 2'b01});

   always_comb begin
      x0 = CW'(req_flow_x) <<< 16;
      y0 = CW'(req_flow_y) <<< 16;
      if (req_flow_x < 0) begin
         x0 = -x0;
         y0 = -y0;
      end
   end

   assign xs     = x_ff >>> cmd.idx;
   assign ys     = y_ff >>> cmd.idx;
   assign dtrial = (cmd.idx == '0) ? {1'b0, rad} : {drem_ff[RAD_W-1:0], 1'b0};
   assign fk     = FK_W'(z_ff) * FK_W'(WHEEL_LAST);

   always_comb begin
      e0 = WHEEL_TABLE[k0_ff];
      e1 = WHEEL_TABLE[k0_ff + 1'b1];
      case (chan_type'(cmd.idx[1:0]))
         CH_RED: begin
            c0 = e0[23:16];
            c1 = e1[23:16];
         end
         CH_GREEN: begin
            c0 = e0[15:8];
            c1 = e1[15:8];
         end
         default: begin
            c0 = e0[7:0];
            c1 = e1[7:0];
         end
      endcase
   end

   assign wf       = {1'b0, f_ff};
   assign wi       = 17'h10000 - wf;
   assign mix      = (CHAN_W+1)'(wi * 17'(c0)) + (CHAN_W+1)'(wf * 17'(c1));
   assign ceil_sum = (PROD_W+1)'(prod_ff) + (PROD_W+1)'(33'hFFFFFFFF);
   assign dark     = (CHAN_W+2)'(c_ff) * (CHAN_W+2)'(3);
   assign chan_val = in_range ? 8'(10'd255 - 10'(ceil_sum[PROD_W:32]))
                              : dark[25:18];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         fx_ff   <= req_flow_x;
         fy_ff   <= req_flow_y;
         unk_ff  <= req_flow_unknown;
         q_ff    <= '0;
         red_ff  <= '0;
         green_ff <= '0;
         blue_ff <= '0;
         x_ff    <= x0;
         y_ff    <= y0;
         if (req_flow_y == '0) begin
            axis_ff <= 1'b1;
            z_ff    <= (req_flow_x < 0) ? 32'h80000000 : 32'h0;
         end else if (req_flow_x == '0) begin
            axis_ff <= 1'b1;
            z_ff    <= (req_flow_y > 0) ? 32'h40000000 : 32'hC0000000;
         end else begin
            axis_ff <= 1'b0;
            z_ff    <= (req_flow_x < 0) ? 32'h80000000 : 32'h0;
         end
      end
      if (cmd.square) begin
         sqx_ff <= SQ_W'(fx_ff * fx_ff);
         sqy_ff <= SQ_W'(fy_ff * fy_ff);
      end
      if (cmd.sqrt_init) begin
         v_ff    <= sqx_ff + sqy_ff;
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         v_ff <= v_ff << 2;
         if (rem_t >= trial) begin
            rem_ff  <= rem_t - trial;
            root_ff <= {root_ff[FLOW_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_t;
            root_ff <= {root_ff[FLOW_WIDTH-2:0], 1'b0};
         end
      end
      if (cmd.cordic_step && !axis_ff) begin
         if (!y_ff[CW-1]) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan_turns(cmd.idx);
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan_turns(cmd.idx);
         end
      end
      if (cmd.div_step) begin
         if (dtrial >= {1'b0, max_ff}) begin
            drem_ff <= dtrial - {1'b0, max_ff};
            q_ff    <= {q_ff[NORM_W-2:0], 1'b1};
         end else begin
            drem_ff <= dtrial;
            q_ff    <= {q_ff[NORM_W-2:0], 1'b0};
         end
      end
      if (cmd.hue) begin
         k0_ff <= fk[FK_W-1:PHASE_W];
         f_ff  <= fk[PHASE_W-1:16];
      end
      if (cmd.chan_mix) begin
         c_ff <= mix[CHAN_W-1:0];
      end
      if (cmd.chan_mult) begin
         prod_ff <= PROD_W'(q_ff) * PROD_W'(FULL - c_ff);
      end
      if (cmd.chan_write) begin
         case (chan_type'(cmd.idx[1:0]))
            CH_RED:   red_ff   <= chan_val;
            CH_GREEN: green_ff <= chan_val;
            default:  blue_ff  <= chan_val;
         endcase
      end
      if (cmd.out_load) begin
         rsp_red_ff   <= red_ff;
         rsp_green_ff <= green_ff;
         rsp_blue_ff  <= blue_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_max) begin
            max_ff <= '0;
         end else if (cmd.update_max && !unk_ff && rad > max_ff) begin
            max_ff <= rad;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

endmodule

### hw/rtl/flow_vector_color_coder.sv
// Flow vector color coder: flow vectors in, color-wheel pixels out.
//
// Input beats (req_) carry a mode, a Q8.8 flow vector and an unknown flag.
// Mode clear zeroes the frame maximum radius; mode scan folds the vector's
// length into that maximum; mode color returns one pixel on the rsp_
// channel; the fourth mode is dropped. Clear and scan give no output beat.
// One beat is worked at a time; req_stall is high while it runs.
// Clear acts on acceptance; scan squares, runs the bit-serial square root
// and updates the maximum; color runs the root, 24 CORDIC steps, 17
// divider steps and the hue, then mix, multiply and write for each of
// three channels, then the output load, skipping the divider when the
// maximum is zero or the vector lies past it. Unknown color beats give black.
// A finished pixel sits in an output register; the next beat is taken
// while it waits. If rsp_stall holds that register full when another pixel
// is done, the block stalls its input until the register frees.
// Reset is synchronous: the frame maximum becomes zero, the output is
// emptied and the sequencer returns to idle.
module flow_vector_color_coder #(
   parameter int FLOW_WIDTH = fvcc_pkg::FLOW_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_mode,
   input  logic signed [FLOW_WIDTH-1:0] req_flow_x,
   input  logic signed [FLOW_WIDTH-1:0] req_flow_y,
   input  logic                         req_flow_unknown,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_red,
   output logic [7:0]                   rsp_green,
   output logic [7:0]                   rsp_blue
);
   import fvcc_pkg::*;

   cmd_type    cmd;
   status_type status;

   fvcc_ctrl #(
      .FLOW_WIDTH (FLOW_WIDTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_flow_unknown (req_flow_unknown),
      .status           (status),
      .cmd              (cmd)
   );

   fvcc_datapath #(
      .FLOW_WIDTH (FLOW_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_flow_x       (req_flow_x),
      .req_flow_y       (req_flow_y),
      .req_flow_unknown (req_flow_unknown),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue)
   );

endmodule
